// ===== rtl/lfrc_pkg.sv =====
// Shared constants, command codes and status types for the local frame register cache.
package lfrc_pkg;

  localparam int CACHE_FRAMES_DEF = 4;

  localparam logic [2:0] OP_CALL  = 3'd0;
  localparam logic [2:0] OP_RET   = 3'd1;
  localparam logic [2:0] OP_FILL  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  localparam logic [2:0] KIND_DONE   = 3'd0;
  localparam logic [2:0] KIND_MWRITE = 3'd1;
  localparam logic [2:0] KIND_MREAD  = 3'd2;
  localparam logic [2:0] KIND_RDATA  = 3'd3;
  localparam logic [2:0] KIND_REJECT = 3'd4;

  localparam logic [31:0] RESET_SP = 32'h0050_0000;
  localparam logic [4:0]  FP_INDEX = 5'd16;
  localparam logic [31:0] FRAME_BYTES = 32'd64;
  localparam logic [31:0] ALIGN_ADD = 32'd63;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_SINGLE,
    CMD_CALL_BEGIN,
    CMD_PUSH_WORD,
    CMD_SPILL_READ,
    CMD_SPILL_WORD,
    CMD_CALL_DONE,
    CMD_RET_BEGIN,
    CMD_POP_READ,
    CMD_POP_LOAD,
    CMD_RET_DONE,
    CMD_REQ_WORD
  } cmd_t;

  typedef struct packed {
    logic op_call;
    logic op_ret;
    logic full;
    logic empty;
    logic cnt_last;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/local_frame_register_cache.sv =====
// Top level of the local frame register cache: controller and datapath.
//
// Usage: one input channel (in_valid / in_stall) carries operation words: call,
// return, fill word, register write and register read. One output channel
// (out_valid / out_stall) carries result words, the final one of each input
// flagged by last. A word is taken on a rising edge with valid high, stall low.
// Sequencing: a word is accepted and decoded in the cycle after, and a register
// access or a fill word is then handled at decode. A call into a cache with room
// copies the frame into the cache memory one word a cycle; a call with a full
// cache reads and spills 16 words, a cache read and then a result per word that
// waits for the receiver; a return from the cache reloads 16 words with a read
// and a load per word; a return from an empty cache emits 16 read requests.
// Only one word is in progress at a time; the next is taken once it is done.
// Results wait in an output register, so the block finishes internal work
// while the last result is still held.
// Reset clears the registers (r1 holds the initial stack pointer), the frame
// count and any pending fill; cache contents are not cleared.
// When the receiver stalls, the current result holds and the next one waits.
module local_frame_register_cache #(
  parameter int CACHE_FRAMES = lfrc_pkg::CACHE_FRAMES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [31:0] target_ip,
  input  logic [31:0] return_ip,
  input  logic [4:0]  reg_index,
  input  logic [31:0] reg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [31:0] mem_addr,
  output logic [31:0] data,
  output logic [31:0] next_ip,
  output logic        last
);
  import lfrc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // The controller sequences each operation, one command a cycle unless held.
  lfrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the registers, the frame cache and the result register.
  lfrc_datapath #(
    .CACHE_FRAMES (CACHE_FRAMES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .operation (operation),
    .target_ip (target_ip),
    .return_ip (return_ip),
    .reg_index (reg_index),
    .reg_data  (reg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .mem_addr  (mem_addr),
    .data      (data),
    .next_ip   (next_ip),
    .last      (last)
  );

endmodule

// ===== rtl/lfrc_ctrl.sv =====
// Sequencing state machine for the local frame register cache.
module lfrc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  lfrc_pkg::stat_t stat,
  output lfrc_pkg::cmd_t  cmd
);
  import lfrc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_PUSH, S_SPILL_RD, S_SPILL_WR, S_CALL_FIN,
    S_POP_RD, S_POP_LD, S_RET_FIN, S_REQ
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = CMD_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd = CMD_CAPTURE;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.op_call) begin
          cmd = CMD_CALL_BEGIN;
          state_next = stat.full ? S_SPILL_RD : S_PUSH;
        end else if (stat.op_ret) begin
          cmd = CMD_RET_BEGIN;
          state_next = stat.empty ? S_REQ : S_POP_RD;
        end else if (stat.out_free) begin
          cmd = CMD_SINGLE;
          state_next = S_IDLE;
        end
      end
      S_PUSH: begin
        cmd = CMD_PUSH_WORD;
        if (stat.cnt_last) state_next = S_CALL_FIN;
      end
      S_SPILL_RD: begin
        cmd = CMD_SPILL_READ;
        state_next = S_SPILL_WR;
      end
      S_SPILL_WR: begin
        if (stat.out_free) begin
          cmd = CMD_SPILL_WORD;
          state_next = stat.cnt_last ? S_CALL_FIN : S_SPILL_RD;
        end
      end
      S_CALL_FIN: begin
        if (stat.out_free) begin
          cmd = CMD_CALL_DONE;
          state_next = S_IDLE;
        end
      end
      S_POP_RD: begin
        cmd = CMD_POP_READ;
        state_next = S_POP_LD;
      end
      S_POP_LD: begin
        cmd = CMD_POP_LOAD;
        state_next = stat.cnt_last ? S_RET_FIN : S_POP_RD;
      end
      S_RET_FIN: begin
        if (stat.out_free) begin
          cmd = CMD_RET_DONE;
          state_next = S_IDLE;
        end
      end
      S_REQ: begin
        if (stat.out_free) begin
          cmd = CMD_REQ_WORD;
          if (stat.cnt_last) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A new word may only be taken while no earlier one is in progress.
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_DISPATCH))
    else $error("accepted word did not reach dispatch");

  // Each cache read is followed by its write or load state next cycle.
  a_spill_pair: assert property (@(posedge clk) disable iff (rst)
    (state == S_SPILL_RD) |=> (state == S_SPILL_WR))
    else $error("spill read not followed by spill write");

  a_pop_pair: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP_RD) |=> (state == S_POP_LD))
    else $error("pop read not followed by pop load");

endmodule

// ===== rtl/lfrc_datapath.sv =====
// Register file, frame cache memory and result register of the local frame register cache.
module lfrc_datapath #(
  parameter int CACHE_FRAMES = lfrc_pkg::CACHE_FRAMES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  lfrc_pkg::cmd_t  cmd,
  output lfrc_pkg::stat_t stat,
  input  logic [2:0]    operation,
  input  logic [31:0]   target_ip,
  input  logic [31:0]   return_ip,
  input  logic [4:0]    reg_index,
  input  logic [31:0]   reg_data,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [2:0]    kind,
  output logic [31:0]   mem_addr,
  output logic [31:0]   data,
  output logic [31:0]   next_ip,
  output logic          last
);
  import lfrc_pkg::*;

  localparam int SW = (CACHE_FRAMES > 1) ? $clog2(CACHE_FRAMES) : 1;
  localparam int CW = $clog2(CACHE_FRAMES + 1);
  localparam int AW = SW + 4;
  localparam int DEPTH = CACHE_FRAMES * 16;
  localparam logic [CW:0] NFR = (CW + 1)'(CACHE_FRAMES);
  localparam logic [SW-1:0] HEAD_MAX = SW'(CACHE_FRAMES - 1);

  logic [2:0]  op_q;
  logic [31:0] target_q, ret_q, val_q;
  logic [4:0]  idx_q;

  logic [31:0] local_regs [16];
  logic [31:0] frame_pointer;
  logic [31:0] cache_mem [DEPTH];
  logic [31:0] frame_addr [CACHE_FRAMES];
  logic [31:0] mem_rdata;
  logic [CW-1:0] cached_count;
  logic [SW-1:0] head;
  logic [3:0]  cnt;
  logic        fill_pending;
  logic [3:0]  fill_index;
  logic [31:0] fill_base;

  logic [CW:0]   tail_sum, tail_w, top_sum, top_w;
  logic [SW-1:0] tail, top;
  logic [3:0]    lr_sel;
  logic [31:0]   lr_rd;
  logic [31:0]   fp_aligned, sp_round;
  logic          reject, cnt_last, out_free, load_out;
  logic [2:0]    kind_next;
  logic [31:0]   addr_next, data_next, ip_next;
  logic          last_next;

  assign tail_sum = (CW + 1)'(head) + (CW + 1)'(cached_count);
  assign tail_w   = (tail_sum >= NFR) ? tail_sum - NFR : tail_sum;
  assign tail     = tail_w[SW-1:0];
  assign top_sum  = tail_sum - (CW + 1)'(1);
  assign top_w    = (top_sum >= NFR) ? top_sum - NFR : top_sum;
  assign top      = top_w[SW-1:0];

  assign lr_sel = (cmd == CMD_PUSH_WORD || cmd == CMD_SPILL_WORD) ? cnt : idx_q[3:0];
  assign lr_rd  = local_regs[lr_sel];

  assign fp_aligned = {frame_pointer[31:6], 6'b0};
  assign sp_round   = local_regs[1] + ALIGN_ADD;
  assign cnt_last   = (cnt == 4'd15);
  assign out_free   = !out_valid || !out_stall;

  assign reject = (fill_pending && op_q != OP_FILL) || (op_q > OP_READ) ||
                  (!fill_pending && op_q == OP_FILL) ||
                  ((op_q == OP_WRITE || op_q == OP_READ) && idx_q > FP_INDEX);

  assign stat.op_call  = !fill_pending && op_q == OP_CALL;
  assign stat.op_ret   = !fill_pending && op_q == OP_RET;
  assign stat.full     = (cached_count == CW'(CACHE_FRAMES));
  assign stat.empty    = (cached_count == '0);
  assign stat.cnt_last = cnt_last;
  assign stat.out_free = out_free;

  // Result selection.
  always_comb begin
    load_out  = 1'b0;
    kind_next = KIND_DONE;
    addr_next = '0;
    data_next = '0;
    ip_next   = '0;
    last_next = 1'b1;
    case (cmd)
      CMD_SINGLE: begin
        if (reject) begin
          load_out  = 1'b1;
          kind_next = KIND_REJECT;
        end else if (op_q == OP_FILL) begin
          load_out = (fill_index == 4'd15);
          ip_next  = local_regs[2];
        end else if (op_q == OP_WRITE) begin
          load_out = 1'b1;
        end else begin
          load_out  = 1'b1;
          kind_next = KIND_RDATA;
          data_next = (idx_q == FP_INDEX) ? frame_pointer : lr_rd;
        end
      end
      CMD_SPILL_WORD: begin
        load_out  = 1'b1;
        kind_next = KIND_MWRITE;
        addr_next = frame_addr[head] + {26'b0, cnt, 2'b00};
        data_next = mem_rdata;
        last_next = 1'b0;
      end
      CMD_CALL_DONE: begin
        load_out = 1'b1;
        ip_next  = target_q;
      end
      CMD_RET_DONE: begin
        load_out = 1'b1;
        ip_next  = local_regs[2];
      end
      CMD_REQ_WORD: begin
        load_out  = 1'b1;
        kind_next = KIND_MREAD;
        addr_next = fill_base + {26'b0, cnt, 2'b00};
        last_next = cnt_last;
      end
      default: load_out = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      kind     <= kind_next;
      mem_addr <= addr_next;
      data     <= data_next;
      next_ip  <= ip_next;
      last     <= last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_CAPTURE) begin
      op_q     <= operation;
      target_q <= target_ip;
      ret_q    <= return_ip;
      idx_q    <= reg_index;
      val_q    <= reg_data;
    end
  end

  // Frame cache memory.
  always_ff @(posedge clk) begin
    if (cmd == CMD_PUSH_WORD) begin
      cache_mem[AW'({tail, cnt})] <= lr_rd;
    end else if (cmd == CMD_SPILL_WORD) begin
      cache_mem[AW'({head, cnt})] <= lr_rd;
    end
    if (cmd == CMD_SPILL_READ) begin
      mem_rdata <= cache_mem[AW'({head, cnt})];
    end else if (cmd == CMD_POP_READ) begin
      mem_rdata <= cache_mem[AW'({top, cnt})];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_PUSH_WORD && cnt_last) begin
      frame_addr[tail] <= frame_pointer;
    end else if (cmd == CMD_SPILL_WORD && cnt_last) begin
      frame_addr[head] <= frame_pointer;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) local_regs[i] <= (i == 1) ? RESET_SP : '0;
      frame_pointer <= '0;
      cached_count  <= '0;
      head          <= '0;
      cnt           <= '0;
      fill_pending  <= 1'b0;
      fill_index    <= '0;
      fill_base     <= '0;
    end else begin
      case (cmd)
        CMD_SINGLE: begin
          if (!reject) begin
            if (op_q == OP_FILL) begin
              local_regs[fill_index] <= val_q;
              fill_index <= fill_index + 4'd1;
              if (fill_index == 4'd15) begin
                fill_pending  <= 1'b0;
                frame_pointer <= fill_base;
              end
            end else if (op_q == OP_WRITE) begin
              if (idx_q == FP_INDEX) frame_pointer <= val_q;
              else local_regs[idx_q[3:0]] <= val_q;
            end
          end
        end
        CMD_CALL_BEGIN: begin
          local_regs[2] <= ret_q;
          cnt <= '0;
        end
        CMD_PUSH_WORD: begin
          cnt <= cnt + 4'd1;
          if (cnt_last) cached_count <= cached_count + CW'(1);
        end
        CMD_SPILL_WORD: begin
          cnt <= cnt + 4'd1;
          if (cnt_last) head <= (head == HEAD_MAX) ? '0 : head + SW'(1);
        end
        CMD_CALL_DONE: begin
          local_regs[0] <= fp_aligned;
          frame_pointer <= {sp_round[31:6], 6'b0};
          local_regs[1] <= {sp_round[31:6], 6'b0} + FRAME_BYTES;
          for (int i = 3; i < 16; i++) local_regs[i] <= '0;
        end
        CMD_RET_BEGIN: begin
          fill_base <= {local_regs[0][31:6], 6'b0};
          cnt <= '0;
        end
        CMD_POP_LOAD: begin
          local_regs[cnt] <= mem_rdata;
          cnt <= cnt + 4'd1;
          if (cnt_last) cached_count <= cached_count - CW'(1);
        end
        CMD_RET_DONE: frame_pointer <= fill_base;
        CMD_REQ_WORD: begin
          cnt <= cnt + 4'd1;
          if (cnt_last) begin
            fill_pending <= 1'b1;
            fill_index   <= '0;
          end
        end
        default: cnt <= cnt;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    cached_count <= CW'(CACHE_FRAMES))
    else $error("frame count beyond cache size");

  a_fill_empty: assert property (@(posedge clk) disable iff (rst)
    fill_pending |-> (cached_count == '0))
    else $error("fill pending with frames cached");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_out |-> out_free)
    else $error("result register overwritten while stalled");

endmodule
